### hw/rtl/apsd_pkg.sv
// Shared types and constants for the accelerometer pedometer step detector.
// No dependencies; every other file of the block refers to it by scoped names.

package apsd_pkg;

	// Three acceleration axes, handled as parallel lanes.
	localparam int AXES = 3;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// Register field widths.
	localparam int DYN_PREC_W = 15;
	localparam int ACT_PREC_W = 16;
	localparam int THR_FRAC_W = 8;
	localparam int WIN_LEN_W  = 8;

	// Result field widths.
	localparam int STEP_W = 32;
	localparam int AXIS_W = 2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DYN_PREC = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACT_PREC = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_FRAC = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN  = 4'd3;

	// Register values after reset.
	localparam logic [DYN_PREC_W-1:0] DYN_PREC_RST = 15'd205;
	localparam logic [ACT_PREC_W-1:0] ACT_PREC_RST = 16'd256;
	localparam logic [THR_FRAC_W-1:0] THR_FRAC_RST = 8'd77;
	localparam logic [WIN_LEN_W-1:0]  WIN_LEN_RST  = 8'd15;

	// Active axis codes.
	localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_X    = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd2;
	localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd3;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [DYN_PREC_W-1:0] dyn_prec;
		logic [ACT_PREC_W-1:0] act_prec;
		logic [THR_FRAC_W-1:0] thr_frac;
		logic [WIN_LEN_W-1:0]  win_len;
	} cfg_t;

endpackage

### hw/rtl/apsd_if.sv
// Channel interfaces of the pedometer step detector: samples, results, configuration.
// Depends on apsd_pkg for field widths.

interface apsd_sample_if #(parameter int SAMPLE_BITS = 16) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] accel_x;
	logic signed [SAMPLE_BITS-1:0] accel_y;
	logic signed [SAMPLE_BITS-1:0] accel_z;

	modport source (output valid, output accel_x, output accel_y, output accel_z,
		input ready);
	modport sink (input valid, input accel_x, input accel_y, input accel_z,
		output ready);
endinterface

interface apsd_result_if ();
	logic                          valid;
	logic                          ready;
	logic [apsd_pkg::STEP_W-1:0]   total_steps;
	logic                          slide_moved;
	logic                          step_seen;
	logic [apsd_pkg::AXIS_W-1:0]   active_axis;

	modport source (output valid, output total_steps, output slide_moved,
		output step_seen, output active_axis, input ready);
	modport sink (input valid, input total_steps, input slide_moved,
		input step_seen, input active_axis, output ready);
endinterface

interface apsd_cfg_if ();
	logic                            valid;
	logic                            ready;
	logic [apsd_pkg::CFG_IDX_W-1:0]  index;
	logic [apsd_pkg::CFG_DATA_W-1:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

### hw/rtl/apsd_cfg_regs.sv
// Configuration register file of the pedometer step detector.
// Depends on apsd_pkg and apsd_cfg_if.

module apsd_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	apsd_cfg_if.sink       cfg,
	output apsd_pkg::cfg_t regs
);

	apsd_pkg::cfg_t regs_q;

	// Writes never stall.
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Decode the index of each write beat; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.dyn_prec <= apsd_pkg::DYN_PREC_RST;
			regs_q.act_prec <= apsd_pkg::ACT_PREC_RST;
			regs_q.thr_frac <= apsd_pkg::THR_FRAC_RST;
			regs_q.win_len  <= apsd_pkg::WIN_LEN_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				apsd_pkg::CFG_DYN_PREC: regs_q.dyn_prec <= cfg.wdata[apsd_pkg::DYN_PREC_W-1:0];
				apsd_pkg::CFG_ACT_PREC: regs_q.act_prec <= cfg.wdata[apsd_pkg::ACT_PREC_W-1:0];
				apsd_pkg::CFG_THR_FRAC: regs_q.thr_frac <= cfg.wdata[apsd_pkg::THR_FRAC_W-1:0];
				apsd_pkg::CFG_WIN_LEN:  regs_q.win_len  <= cfg.wdata[apsd_pkg::WIN_LEN_W-1:0];
				default:                regs_q          <= regs_q;
			endcase
		end
	end

endmodule

### hw/rtl/apsd_mean.sv
// Moving-mean front end: tap ring memory, running sums and a floor divide by the tap count.
// Depends on apsd_pkg.

module apsd_mean #(
	parameter int MEAN_TAPS   = 4,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] in_x,
	input  logic signed [SAMPLE_BITS-1:0] in_y,
	input  logic signed [SAMPLE_BITS-1:0] in_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] smooth [apsd_pkg::AXES]
);

	localparam int AXES   = apsd_pkg::AXES;
	localparam int SB     = SAMPLE_BITS;
	localparam int TAP_W  = $clog2(MEAN_TAPS);
	localparam int SLOT_W = TAP_W;
	localparam int UW     = SB + TAP_W;
	localparam int K      = UW + TAP_W;
	localparam int MW     = UW + 2;
	localparam int UL     = UW / 2;
	localparam int UH     = UW - UL;
	localparam int ML     = MW / 2;
	localparam int MH     = MW - ML;
	localparam int PW     = UW + MW;

	// Reciprocal of the tap count, exact for every biased sum below 2**UW.
	localparam logic [MW-1:0] RECIP = MW'(((64'd1 << K) / 64'(MEAN_TAPS)) + 64'd1);
	localparam logic [ML-1:0] RECIP_LO = RECIP[ML-1:0];
	localparam logic [MH-1:0] RECIP_HI = RECIP[MW-1:ML];
	// Bias that makes every sum non-negative.
	localparam logic [UW-1:0] BIAS = UW'(64'(MEAN_TAPS) << (SB - 1));
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MEAN_TAPS - 1);

	// Tap ring: one row per slot, all three axes side by side.
	logic [AXES*SB-1:0] ring_mem [MEAN_TAPS];
	logic [AXES*SB-1:0] ring_rd_q;
	logic [MEAN_TAPS-1:0] vb_q;
	logic [SLOT_W-1:0]    slot_q;

	logic signed [UW-1:0] sum_q [AXES];

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3, acc, mv1;

	logic signed [SB-1:0] new_s1 [AXES];
	logic                 evv_s1;
	logic [UW-1:0]        u_s2 [AXES];
	logic [UL+ML-1:0]     pll_s3 [AXES];
	logic [UL+MH-1:0]     plh_s3 [AXES];
	logic [UH+ML-1:0]     phl_s3 [AXES];
	logic [UH+MH-1:0]     phh_s3 [AXES];

	logic signed [SB-1:0] ev [AXES];
	logic signed [UW-1:0] sum_nx [AXES];
	logic [UW-1:0]        u [AXES];
	logic [PW-1:0]        prod [AXES];
	logic [SB-1:0]        quo [AXES];

	// Stage enables ripple back from the output.
	assign en3       = !v_s3 || out_ready;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign in_ready  = en1;
	assign acc       = in_valid && en1;
	assign mv1       = v_s1 && en2;
	assign out_valid = v_s3;

	// The ring is read before it is written, so one port pair serves the evicted tap.
	always_ff @(posedge clk) begin
		if (acc) begin
			ring_rd_q        <= ring_mem[slot_q];
			ring_mem[slot_q] <= {in_z, in_y, in_x};
		end
	end

	// Control state, slot valid bits and running sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb_q   <= '0;
			slot_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= '0;
			end
		end else begin
			if (acc) begin
				vb_q[slot_q] <= 1'b1;
				slot_q       <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
			end
			if (en1) begin
				v_s1 <= acc;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (mv1) begin
				for (int a = 0; a < AXES; a++) begin
					sum_q[a] <= sum_nx[a];
				end
			end
		end
	end

	// Stage 1: replace the evicted tap in the running sum and bias it.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			ev[a]     = evv_s1 ? $signed(ring_rd_q[a*SB +: SB]) : '0;
			sum_nx[a] = sum_q[a] - UW'(ev[a]) + UW'(new_s1[a]);
			u[a]      = $unsigned(sum_nx[a]) + BIAS;
		end
	end

	// Stage 3: add the partial products and take the quotient.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			prod[a] = PW'(pll_s3[a]) + (PW'(plh_s3[a]) << ML) + (PW'(phl_s3[a]) << UL)
				+ (PW'(phh_s3[a]) << (UL + ML));
			quo[a]    = prod[a][K +: SB];
			// Removing the bias flips the top bit of the quotient.
			smooth[a] = $signed({~quo[a][SB-1], quo[a][SB-2:0]});
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (acc) begin
			new_s1[0] <= in_x;
			new_s1[1] <= in_y;
			new_s1[2] <= in_z;
			evv_s1    <= vb_q[slot_q];
		end
		if (en2 && v_s1) begin
			for (int a = 0; a < AXES; a++) begin
				u_s2[a] <= u[a];
			end
		end
		// Stage 2: four half-width partial products against the reciprocal.
		if (en3 && v_s2) begin
			for (int a = 0; a < AXES; a++) begin
				pll_s3[a] <= (UL+ML)'(u_s2[a][UL-1:0]) * (UL+ML)'(RECIP_LO);
				plh_s3[a] <= (UL+MH)'(u_s2[a][UL-1:0]) * (UL+MH)'(RECIP_HI);
				phl_s3[a] <= (UH+ML)'(u_s2[a][UW-1:UL]) * (UH+ML)'(RECIP_LO);
				phh_s3[a] <= (UH+MH)'(u_s2[a][UW-1:UL]) * (UH+MH)'(RECIP_HI);
			end
		end
	end

	// A taken beat always lands in stage 1.
	a_acc_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> v_s1)
		else $error("accepted sample did not reach stage 1");

	// The ring slot never leaves the ring.
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(slot_q) < MEAN_TAPS)
		else $error("ring slot out of range");

endmodule

### hw/rtl/apsd_track.sv
// Peak tracking, slide registers, active axis choice and step decision, with result register.
// Depends on apsd_pkg.

module apsd_track #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  apsd_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] smooth [apsd_pkg::AXES],
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [apsd_pkg::STEP_W-1:0]   total_steps,
	output logic                          slide_moved,
	output logic                          step_seen,
	output logic [apsd_pkg::AXIS_W-1:0]   active_axis
);

	localparam int AXES   = apsd_pkg::AXES;
	localparam int SB     = SAMPLE_BITS;
	localparam int DW     = SB + 1;
	localparam int PCMP_W = (DW > apsd_pkg::ACT_PREC_W) ? DW : apsd_pkg::ACT_PREC_W;
	localparam int FW     = apsd_pkg::THR_FRAC_W;
	localparam int PROD_W = DW + FW + 1;
	localparam int THR_W  = PROD_W + 1;
	localparam int WW     = apsd_pkg::WIN_LEN_W;

	localparam logic signed [SB-1:0] MOST_NEG = {1'b1, {(SB-1){1'b0}}};
	localparam logic signed [SB-1:0] MOST_POS = {1'b0, {(SB-1){1'b1}}};

	// Tracking state.
	logic [WW-1:0]               win_cnt_q;
	logic signed [SB-1:0]        cmax_q [AXES];
	logic signed [SB-1:0]        cmin_q [AXES];
	logic signed [SB-1:0]        pmax_q [AXES];
	logic signed [SB-1:0]        pmin_q [AXES];
	logic signed [SB-1:0]        slide_q [AXES];
	logic [apsd_pkg::STEP_W-1:0] step_total_q;

	// Stage valids and enables.
	logic v_s1, v_s2, v_s3, v_s4, ov_q;
	logic en1, en2, en3, en4, en_out, mv1, mv4;

	// Stage payload.
	logic signed [SB-1:0] smooth_s1 [AXES];
	logic signed [SB-1:0] cmax_s2 [AXES];
	logic signed [SB-1:0] cmin_s2 [AXES];
	logic signed [SB-1:0] pmax_s2 [AXES];
	logic signed [SB-1:0] pmin_s2 [AXES];
	logic signed [SB-1:0] old_s2 [AXES];
	logic signed [SB-1:0] new_s2 [AXES];
	logic                 moved_s2;
	logic [DW-1:0]        span_s3 [AXES];
	logic signed [DW-1:0] ospan_s3 [AXES];
	logic signed [SB-1:0] pmin_s3 [AXES];
	logic signed [SB-1:0] old_s3 [AXES];
	logic signed [SB-1:0] new_s3 [AXES];
	logic                 moved_s3;
	logic [apsd_pkg::AXIS_W-1:0] axis_s4;
	logic signed [PROD_W-1:0]    prod_s4 [AXES];
	logic signed [SB-1:0]        pmin_s4 [AXES];
	logic signed [SB-1:0]        old_s4 [AXES];
	logic signed [SB-1:0]        new_s4 [AXES];
	logic                        moved_s4;
	logic                        moved_q;
	logic                        step_q;
	logic [apsd_pkg::AXIS_W-1:0] axis_q;

	// Stage 1 signals.
	logic [WW:0]          win_next;
	logic                 win_end;
	logic signed [SB-1:0] nmax [AXES];
	logic signed [SB-1:0] nmin [AXES];
	logic signed [SB-1:0] npmax [AXES];
	logic signed [SB-1:0] npmin [AXES];
	logic signed [SB-1:0] nslide [AXES];
	logic signed [DW-1:0] sdiff [AXES];
	logic [DW-1:0]        smag [AXES];
	logic [AXES-1:0]      take;

	// Stage 2 to 4 signals.
	logic signed [DW-1:0]        cdiff [AXES];
	logic [DW-1:0]               span [AXES];
	logic signed [DW-1:0]        ospan [AXES];
	logic [AXES-1:0]             act_ok;
	logic [AXES-1:0]             lead;
	logic [apsd_pkg::AXIS_W-1:0] axis_nx;
	logic signed [PROD_W-1:0]    prod [AXES];
	logic signed [SB-1:0]        pmin_sel;
	logic signed [SB-1:0]        old_sel;
	logic signed [SB-1:0]        new_sel;
	logic signed [PROD_W-1:0]    prod_sel;
	logic signed [THR_W-1:0]     thr;
	logic signed [THR_W-1:0]     old_sc;
	logic signed [THR_W-1:0]     new_sc;
	logic                        step_nx;

	// Stage enables ripple back from the result register.
	assign en_out    = !ov_q || out_ready;
	assign en4       = !v_s4 || en_out;
	assign en3       = !v_s3 || en4;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign in_ready  = en1;
	assign mv1       = v_s1 && en2;
	assign mv4       = v_s4 && en_out;

	assign out_valid   = ov_q;
	assign total_steps = step_total_q;
	assign slide_moved = moved_q;
	assign step_seen   = step_q;
	assign active_axis = axis_q;

	// Stage 1: window bookkeeping, peak tracking and slide registers.
	always_comb begin
		win_next = {1'b0, win_cnt_q} + (WW+1)'(1);
		win_end  = win_next > {1'b0, cfg.win_len};
		for (int a = 0; a < AXES; a++) begin
			nmax[a]  = win_end ? MOST_NEG : cmax_q[a];
			nmin[a]  = win_end ? MOST_POS : cmin_q[a];
			if (smooth_s1[a] > nmax[a]) begin
				nmax[a] = smooth_s1[a];
			end
			if (smooth_s1[a] < nmin[a]) begin
				nmin[a] = smooth_s1[a];
			end
			npmax[a] = win_end ? cmax_q[a] : pmax_q[a];
			npmin[a] = win_end ? cmin_q[a] : pmin_q[a];
			sdiff[a] = DW'(smooth_s1[a]) - DW'(slide_q[a]);
			smag[a]  = sdiff[a][DW-1] ? $unsigned(-sdiff[a]) : $unsigned(sdiff[a]);
			take[a]  = PCMP_W'(smag[a]) > PCMP_W'(cfg.dyn_prec);
			nslide[a] = take[a] ? smooth_s1[a] : slide_q[a];
		end
	end

	// Stage 2: current span and previous span per axis.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			cdiff[a] = DW'(cmax_s2[a]) - DW'(cmin_s2[a]);
			span[a]  = cdiff[a][DW-1] ? $unsigned(-cdiff[a]) : $unsigned(cdiff[a]);
			ospan[a] = DW'(pmax_s2[a]) - DW'(pmin_s2[a]);
		end
	end

	// Stage 3: pick the axis with the strictly largest span; scale old spans.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			act_ok[a] = PCMP_W'(span_s3[a]) >= PCMP_W'(cfg.act_prec);
			prod[a]   = PROD_W'(ospan_s3[a]) * PROD_W'($signed({1'b0, cfg.thr_frac}));
		end
		lead[0] = (span_s3[0] > span_s3[1]) && (span_s3[0] > span_s3[2]) && act_ok[0];
		lead[1] = (span_s3[1] > span_s3[2]) && (span_s3[1] > span_s3[0]) && act_ok[1];
		lead[2] = (span_s3[2] > span_s3[0]) && (span_s3[2] > span_s3[1]) && act_ok[2];
		priority if (!moved_s3) begin
			axis_nx = apsd_pkg::AXIS_NONE;
		end else if (lead[0]) begin
			axis_nx = apsd_pkg::AXIS_X;
		end else if (lead[1]) begin
			axis_nx = apsd_pkg::AXIS_Y;
		end else if (lead[2]) begin
			axis_nx = apsd_pkg::AXIS_Z;
		end else begin
			axis_nx = apsd_pkg::AXIS_NONE;
		end
	end

	// Stage 4: crossing of the dynamic threshold on the chosen axis, all scaled by 256.
	always_comb begin
		unique case (axis_s4)
			apsd_pkg::AXIS_X: begin
				pmin_sel = pmin_s4[0];
				prod_sel = prod_s4[0];
				old_sel  = old_s4[0];
				new_sel  = new_s4[0];
			end
			apsd_pkg::AXIS_Y: begin
				pmin_sel = pmin_s4[1];
				prod_sel = prod_s4[1];
				old_sel  = old_s4[1];
				new_sel  = new_s4[1];
			end
			apsd_pkg::AXIS_Z: begin
				pmin_sel = pmin_s4[2];
				prod_sel = prod_s4[2];
				old_sel  = old_s4[2];
				new_sel  = new_s4[2];
			end
			apsd_pkg::AXIS_NONE: begin
				pmin_sel = '0;
				prod_sel = '0;
				old_sel  = '0;
				new_sel  = '0;
			end
		endcase
		thr     = (THR_W'(pmin_sel) << FW) + THR_W'(prod_sel);
		old_sc  = THR_W'(old_sel) << FW;
		new_sc  = THR_W'(new_sel) << FW;
		step_nx = (axis_s4 != apsd_pkg::AXIS_NONE) && (old_sc > thr) && (new_sc < thr);
	end

	// Control and tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			ov_q         <= 1'b0;
			win_cnt_q    <= '0;
			step_total_q <= '0;
			for (int a = 0; a < AXES; a++) begin
				cmax_q[a]  <= MOST_NEG;
				cmin_q[a]  <= MOST_POS;
				pmax_q[a]  <= '0;
				pmin_q[a]  <= '0;
				slide_q[a] <= '0;
			end
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (en_out) begin
				ov_q <= v_s4;
			end
			if (mv1) begin
				win_cnt_q <= win_end ? WW'(1) : win_next[WW-1:0];
				for (int a = 0; a < AXES; a++) begin
					cmax_q[a]  <= nmax[a];
					cmin_q[a]  <= nmin[a];
					pmax_q[a]  <= npmax[a];
					pmin_q[a]  <= npmin[a];
					slide_q[a] <= nslide[a];
				end
			end
			if (mv4) begin
				step_total_q <= step_total_q + apsd_pkg::STEP_W'(step_nx);
			end
		end
	end

	// Pipeline payload and result register.
	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			for (int a = 0; a < AXES; a++) begin
				smooth_s1[a] <= smooth[a];
			end
		end
		if (mv1) begin
			moved_s2 <= |take;
			for (int a = 0; a < AXES; a++) begin
				cmax_s2[a] <= nmax[a];
				cmin_s2[a] <= nmin[a];
				pmax_s2[a] <= npmax[a];
				pmin_s2[a] <= npmin[a];
				old_s2[a]  <= slide_q[a];
				new_s2[a]  <= nslide[a];
			end
		end
		if (en3 && v_s2) begin
			moved_s3 <= moved_s2;
			for (int a = 0; a < AXES; a++) begin
				span_s3[a]  <= span[a];
				ospan_s3[a] <= ospan[a];
				pmin_s3[a]  <= pmin_s2[a];
				old_s3[a]   <= old_s2[a];
				new_s3[a]   <= new_s2[a];
			end
		end
		if (en4 && v_s3) begin
			moved_s4 <= moved_s3;
			axis_s4  <= axis_nx;
			for (int a = 0; a < AXES; a++) begin
				prod_s4[a] <= prod[a];
				pmin_s4[a] <= pmin_s3[a];
				old_s4[a]  <= old_s3[a];
				new_s4[a]  <= new_s3[a];
			end
		end
		if (mv4) begin
			moved_q <= moved_s4;
			step_q  <= step_nx;
			axis_q  <= axis_s4;
		end
	end

	// A counted step always comes with a moved slide and a chosen axis.
	a_step_needs_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && step_q) |-> (moved_q && (axis_q != apsd_pkg::AXIS_NONE)))
		else $error("step counted without a moved slide or an active axis");

	// The running count advances by exactly the step flag of each finished beat.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		mv4 |=> (step_total_q == $past(step_total_q) + apsd_pkg::STEP_W'($past(step_nx))))
		else $error("step count out of step with the step flag");

	// No axis is reported for a beat whose slide did not move.
	a_axis_needs_move: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !moved_q) |-> (axis_q == apsd_pkg::AXIS_NONE))
		else $error("active axis reported without a slide move");

endmodule

### hw/rtl/accel_pedometer_step_detector_core.sv
// Top level of the accelerometer pedometer step detector.
// Depends on apsd_pkg, apsd_if, apsd_cfg_regs, apsd_mean and apsd_track.
//
// Usage:
//   sample : one beat carries accel_x, accel_y, accel_z (signed Q8.8).
//   result : one beat per sample: total_steps, slide_moved, step_seen,
//            active_axis (0 none, 1 x, 2 y, 3 z).
//   cfg    : register writes by index (0 slide precision, 1 activity
//            precision, 2 threshold fraction, 3 window length); always
//            ready; write only while no sample is in flight.
// A sample passes the mean stages, tracking stages and result register.
// Throughput is one sample per cycle without result stalls: the tap ring
// is a single read-before-write memory touched once per sample, and every
// piece of per-axis state is updated in one pipeline stage per beat.
// Reset clears all state at once; the tap ring needs no clearing pass since
// a valid bit per slot makes an unwritten slot read as zero.
// When the result receiver stalls, the result is held and the stages behind
// it keep filling their empty slots; the sample channel drops ready only
// once every stage is occupied.

module accel_pedometer_step_detector_core #(
	parameter int MEAN_TAPS   = 4,
	parameter int SAMPLE_BITS = 16
) (
	input logic            clk,
	input logic            arst_n,
	apsd_sample_if.sink    sample,
	apsd_result_if.source  result,
	apsd_cfg_if.sink       cfg
);

	apsd_pkg::cfg_t regs;

	logic                          mean_valid;
	logic                          mean_ready;
	logic signed [SAMPLE_BITS-1:0] smooth [apsd_pkg::AXES];

	// Register file.
	apsd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	// Moving mean over the tap ring.
	apsd_mean #(
		.MEAN_TAPS   (MEAN_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mean (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.in_x      (sample.accel_x),
		.in_y      (sample.accel_y),
		.in_z      (sample.accel_z),
		.out_valid (mean_valid),
		.out_ready (mean_ready),
		.smooth    (smooth)
	);

	// Peak tracking and step decision.
	apsd_track #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (regs),
		.in_valid    (mean_valid),
		.in_ready    (mean_ready),
		.smooth      (smooth),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.total_steps (result.total_steps),
		.slide_moved (result.slide_moved),
		.step_seen   (result.step_seen),
		.active_axis (result.active_axis)
	);

endmodule

### tb/tb_accel_pedometer_step_detector_core.sv
// Self-checking testbench for the accelerometer pedometer step detector core.
// Depends on apsd_pkg, the apsd channel interfaces and the core RTL; an internal predictor
// computes every result beat, which is then checked field by field against the block.

module tb_accel_pedometer_step_detector_core;

	localparam int TAPS         = 4;
	localparam int SBITS        = 16;
	localparam int PIPE_LATENCY = 7;
	localparam int QUIET_LIMIT  = 2000;
	localparam int IDLE_PCT     = 23;

	// An index that decodes to no register; writes to it must change nothing.
	localparam logic [apsd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 4'd12;

	typedef struct packed {
		logic [apsd_pkg::STEP_W-1:0] total_steps;
		logic                        slide_moved;
		logic                        step_seen;
		logic [apsd_pkg::AXIS_W-1:0] active_axis;
	} step_report_t;

	logic clk;
	logic arst_n;

	apsd_sample_if #(.SAMPLE_BITS(SBITS)) sample_ch ();
	apsd_result_if result_ch ();
	apsd_cfg_if cfg_ch ();

	accel_pedometer_step_detector_core #(
		.MEAN_TAPS(TAPS),
		.SAMPLE_BITS(SBITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	// Free-running clock with a period of 4.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Predictor copy of the configuration registers.
	logic [apsd_pkg::DYN_PREC_W-1:0] cfg_dyn;
	logic [apsd_pkg::ACT_PREC_W-1:0] cfg_act;
	logic [apsd_pkg::THR_FRAC_W-1:0] cfg_frac;
	logic [apsd_pkg::WIN_LEN_W-1:0]  cfg_win;

	// Predictor copy of the datapath state.
	logic signed [SBITS-1:0]     tap_ring [3][TAPS];
	logic [1:0]                  tap_slot;
	logic [7:0]                  win_count;
	logic signed [SBITS-1:0]     win_max [3];
	logic signed [SBITS-1:0]     win_min [3];
	logic signed [SBITS-1:0]     old_max [3];
	logic signed [SBITS-1:0]     old_min [3];
	logic signed [SBITS-1:0]     slide_now [3];
	logic signed [SBITS-1:0]     slide_prev [3];
	logic [apsd_pkg::STEP_W-1:0] pred_total;

	step_report_t reports_due [$];
	int           mismatch_count = 0;
	int           quiet_cycles = 0;
	bit           gaps_on;
	bit           stalls_on;

	// Advances the predicted state by one sample and returns the result it should give.
	function automatic step_report_t pedometer_predict(input logic signed [SBITS-1:0] x,
		input logic signed [SBITS-1:0] y, input logic signed [SBITS-1:0] z);
		int                      smooth [3];
		int                      span [3];
		int                      sum;
		int                      diff;
		int                      nxt;
		int                      k;
		longint                  old_span;
		longint                  thr256;
		logic signed [SBITS-1:0] lane [3];
		bit                      moved;
		bit                      hit;
		bit                      found;
		step_report_t            rep;

		lane[0] = x;
		lane[1] = y;
		lane[2] = z;
		moved = 1'b0;
		hit = 1'b0;
		found = 1'b0;
		k = 0;

		// Moving mean over the tap ring, rounded toward minus infinity.
		for (int a = 0; a < 3; a++) begin
			tap_ring[a][tap_slot] = lane[a];
			sum = 0;
			for (int t = 0; t < TAPS; t++)
				sum += tap_ring[a][t];
			smooth[a] = (sum >= 0) ? sum / TAPS : -((-sum + TAPS - 1) / TAPS);
		end
		tap_slot = tap_slot + 2'd1;

		// Window bookkeeping: a finished window hands its extremes to the old pair.
		nxt = int'(win_count) + 1;
		if (nxt > int'(cfg_win)) begin
			nxt = 1;
			for (int a = 0; a < 3; a++) begin
				old_max[a] = win_max[a];
				old_min[a] = win_min[a];
				win_max[a] = 16'sh8000;
				win_min[a] = 16'sh7FFF;
			end
		end
		win_count = nxt[7:0];
		for (int a = 0; a < 3; a++) begin
			if (smooth[a] > win_max[a])
				win_max[a] = smooth[a][SBITS-1:0];
			if (smooth[a] < win_min[a])
				win_min[a] = smooth[a][SBITS-1:0];
		end

		// Slide register takes the new value only on a change above the precision.
		for (int a = 0; a < 3; a++) begin
			diff = smooth[a] - slide_now[a];
			if (diff < 0)
				diff = -diff;
			slide_prev[a] = slide_now[a];
			if (diff > int'(cfg_dyn)) begin
				slide_now[a] = smooth[a][SBITS-1:0];
				moved = 1'b1;
			end
		end

		// Pick the axis with the strictly widest span, then test the falling crossing.
		if (moved) begin
			for (int a = 0; a < 3; a++) begin
				span[a] = win_max[a] - win_min[a];
				if (span[a] < 0)
					span[a] = -span[a];
			end
			for (int a = 0; a < 3; a++) begin
				if (!found && span[a] > span[(a + 1) % 3] && span[a] > span[(a + 2) % 3] &&
					span[a] >= int'(cfg_act)) begin
					found = 1'b1;
					k = a;
				end
			end
			if (found) begin
				old_span = longint'(old_max[k]) - longint'(old_min[k]);
				thr256 = longint'(old_min[k]) * 256 + old_span * longint'(cfg_frac);
				if (longint'(slide_prev[k]) * 256 > thr256 &&
					longint'(slide_now[k]) * 256 < thr256) begin
					pred_total = pred_total + 1;
					hit = 1'b1;
				end
			end
		end

		rep.total_steps = pred_total;
		rep.slide_moved = moved;
		rep.step_seen = hit;
		if (!found)
			rep.active_axis = apsd_pkg::AXIS_NONE;
		else if (k == 0)
			rep.active_axis = apsd_pkg::AXIS_X;
		else if (k == 1)
			rep.active_axis = apsd_pkg::AXIS_Y;
		else
			rep.active_axis = apsd_pkg::AXIS_Z;
		return rep;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatch_count++;
	endtask

	// Sends one sample beat, with random idle cycles ahead of it, and queues its result.
	task automatic send_accel(input logic signed [SBITS-1:0] x,
		input logic signed [SBITS-1:0] y, input logic signed [SBITS-1:0] z);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.accel_x <= x;
		sample_ch.accel_y <= y;
		sample_ch.accel_z <= z;
		@(posedge clk);
		while (sample_ch.ready !== 1'b1)
			@(posedge clk);
		reports_due.push_back(pedometer_predict(x, y, z));
	endtask

	// Stops sending and waits until every queued result beat has come back.
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (reports_due.size() != 0)
			@(posedge clk);
	endtask

	// One register write beat; valid stays high unless this is the last of a group.
	task automatic write_reg(input logic [apsd_pkg::CFG_IDX_W-1:0] idx,
		input logic [apsd_pkg::CFG_DATA_W-1:0] data, input bit close);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= data;
		@(posedge clk);
		while (cfg_ch.ready !== 1'b1)
			@(posedge clk);
		if (close)
			cfg_ch.valid <= 1'b0;
		case (idx)
			apsd_pkg::CFG_DYN_PREC: cfg_dyn = data[apsd_pkg::DYN_PREC_W-1:0];
			apsd_pkg::CFG_ACT_PREC: cfg_act = data[apsd_pkg::ACT_PREC_W-1:0];
			apsd_pkg::CFG_THR_FRAC: cfg_frac = data[apsd_pkg::THR_FRAC_W-1:0];
			apsd_pkg::CFG_WIN_LEN:  cfg_win = data[apsd_pkg::WIN_LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [apsd_pkg::CFG_DATA_W-1:0] dyn,
		input logic [apsd_pkg::CFG_DATA_W-1:0] act,
		input logic [apsd_pkg::CFG_DATA_W-1:0] frac,
		input logic [apsd_pkg::CFG_DATA_W-1:0] win);
		write_reg(apsd_pkg::CFG_DYN_PREC, dyn, 1'b0);
		write_reg(apsd_pkg::CFG_ACT_PREC, act, 1'b0);
		write_reg(apsd_pkg::CFG_THR_FRAC, frac, 1'b0);
		write_reg(apsd_pkg::CFG_WIN_LEN, win, 1'b1);
	endtask

	// Field extremes under the reset configuration, including negative mean flooring.
	task automatic test_sample_extremes();
		send_accel(16'sh7FFF, 16'sh0000, 16'sh8000);
		send_accel(16'sh7FFF, 16'sh0000, 16'sh8000);
		send_accel(16'sh8000, -16'sh0001, 16'sh7FFF);
		send_accel(16'sh8000, -16'sh0001, 16'sh7FFF);
		send_accel(16'sh0000, 16'sh0001, -16'sh0001);
		send_accel(-16'sh0001, -16'sh0002, -16'sh0003);
		send_accel(16'sh5555, -16'sh5556, 16'sh2AAA);
	endtask

	// Equal spans on all axes, then a tie between x and y only: no axis may be chosen.
	task automatic test_span_ties();
		drain_results();
		set_config(16'd0, 16'd0, 16'd128, 16'd2);
		send_accel(16'sd3000, 16'sd3000, 16'sd3000);
		send_accel(-16'sd3000, -16'sd3000, -16'sd3000);
		send_accel(16'sd2500, 16'sd2500, 16'sd2500);
		send_accel(-16'sd2000, -16'sd2000, -16'sd2000);
		send_accel(16'sd4000, 16'sd4000, 16'sd4000);
		send_accel(-16'sd4000, -16'sd4000, -16'sd4000);
		send_accel(16'sd5000, 16'sd5000, 16'sd0);
		send_accel(-16'sd5000, -16'sd5000, 16'sd0);
		send_accel(16'sd6000, 16'sd6000, 16'sd0);
	endtask

	// Zero window length, masked register data, an unused index, and a window
	// length lowered below the running count.
	task automatic test_window_edges();
		drain_results();
		// The unused index closes the group, so valid stays high across all five beats.
		write_reg(apsd_pkg::CFG_DYN_PREC, 16'hFFFF, 1'b0);
		write_reg(apsd_pkg::CFG_ACT_PREC, 16'hFFFF, 1'b0);
		write_reg(apsd_pkg::CFG_THR_FRAC, 16'hFF00, 1'b0);
		write_reg(apsd_pkg::CFG_WIN_LEN, 16'hFF00, 1'b0);
		write_reg(CFG_UNUSED, 16'hFFFF, 1'b1);
		send_accel(16'sh7FFF, 16'sh8000, 16'sh0100);
		send_accel(16'sh8000, 16'sh7FFF, -16'sh0100);
		send_accel(16'sh1234, -16'sh4321, 16'sh0000);
		drain_results();
		set_config({1'b0, apsd_pkg::DYN_PREC_RST}, apsd_pkg::ACT_PREC_RST,
			{8'd0, apsd_pkg::THR_FRAC_RST}, 16'd200);
		send_accel(16'sd2000, -16'sd300, 16'sd100);
		send_accel(-16'sd2500, 16'sd300, 16'sd100);
		send_accel(16'sd3000, -16'sd300, -16'sd100);
		send_accel(-16'sd3500, 16'sd300, -16'sd100);
		send_accel(16'sd1000, 16'sd0, 16'sd0);
		drain_results();
		write_reg(apsd_pkg::CFG_WIN_LEN, 16'd2, 1'b1);
		send_accel(-16'sd4000, 16'sd200, 16'sd50);
		send_accel(16'sd4000, -16'sd200, -16'sd50);
	endtask

	// Walking-like triangle waves on a dominant axis with noise, under a range of
	// settings. The first burst runs without any idling on either side.
	task automatic test_gait_sequences();
		int major;
		int amp;
		int period;
		int half;
		int noise;
		int len;
		int ph;
		int wave;
		int offset [3];
		int v [3];

		for (int burst = 0; burst < 10; burst++) begin
			drain_results();
			if (burst == 0)
				set_config({1'b0, apsd_pkg::DYN_PREC_RST}, apsd_pkg::ACT_PREC_RST,
					{8'd0, apsd_pkg::THR_FRAC_RST}, {8'd0, apsd_pkg::WIN_LEN_RST});
			else if (burst == 1)
				set_config(16'd0, 16'd0, 16'd0, 16'd1);
			else if (burst == 2)
				set_config(16'd32767, 16'd65535, 16'd255, 16'd255);
			else
				set_config(16'($urandom_range(600)), 16'($urandom_range(2000)),
					16'($urandom_range(255)), 16'($urandom_range(40, 2)));
			gaps_on = (burst != 0);
			stalls_on = (burst != 0);
			len = (burst == 0) ? 150 : int'($urandom_range(40, 25));
			major = $urandom_range(2);
			amp = $urandom_range(12000, 300);
			period = $urandom_range(40, 6);
			half = period / 2;
			noise = $urandom_range(400);
			for (int a = 0; a < 3; a++)
				offset[a] = int'($urandom_range(6000)) - 3000;
			for (int i = 0; i < len; i++) begin
				ph = i % period;
				if (ph < half)
					wave = -amp + (2 * amp * ph) / half;
				else
					wave = amp - (2 * amp * (ph - half)) / (period - half);
				for (int a = 0; a < 3; a++) begin
					v[a] = offset[a] + ((a == major) ? wave : wave / 8) +
						int'($urandom_range(2 * noise)) - noise;
					if (v[a] > 32767)
						v[a] = 32767;
					if (v[a] < -32768)
						v[a] = -32768;
				end
				send_accel(v[0][15:0], v[1][15:0], v[2][15:0]);
			end
		end
	endtask

	// Full-range random samples that follow no pattern at all.
	task automatic test_noise();
		drain_results();
		set_config(16'($urandom_range(32767)), 16'($urandom_range(65535)),
			16'($urandom_range(255)), 16'($urandom_range(255)));
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		for (int i = 0; i < 70; i++)
			send_accel(16'($urandom()), 16'($urandom()), 16'($urandom()));
	endtask

	// Result sink: random back-pressure and a field-by-field check of every beat.
	initial begin : result_sink
		step_report_t want;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				if (reports_due.size() == 0) begin
					report_mismatch("result beat with no sample outstanding");
				end else begin
					want = reports_due.pop_front();
					if (result_ch.total_steps !== want.total_steps)
						report_mismatch($sformatf("total_steps got %0d want %0d",
							result_ch.total_steps, want.total_steps));
					if (result_ch.slide_moved !== want.slide_moved)
						report_mismatch($sformatf("slide_moved got %b want %b",
							result_ch.slide_moved, want.slide_moved));
					if (result_ch.step_seen !== want.step_seen)
						report_mismatch($sformatf("step_seen got %b want %b",
							result_ch.step_seen, want.step_seen));
					if (result_ch.active_axis !== want.active_axis)
						report_mismatch($sformatf("active_axis got %0d want %0d",
							result_ch.active_axis, want.active_axis));
				end
			end
			result_ch.ready <= !(stalls_on && $urandom_range(99) < IDLE_PCT);
		end
	end

	// Watchdog: ends the run once no channel has moved a beat for too long.
	always @(posedge clk) begin
		if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
			(result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
			(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("accel_pedometer_step_detector_core test failed");
			$finish;
		end
	end

	// Main sequence: reset, directed tests, random tests, final drain and verdict.
	initial begin
		arst_n <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.accel_x <= '0;
		sample_ch.accel_y <= '0;
		sample_ch.accel_z <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= apsd_pkg::CFG_DYN_PREC;
		cfg_ch.wdata <= '0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;

		// Predictor state after reset.
		cfg_dyn = apsd_pkg::DYN_PREC_RST;
		cfg_act = apsd_pkg::ACT_PREC_RST;
		cfg_frac = apsd_pkg::THR_FRAC_RST;
		cfg_win = apsd_pkg::WIN_LEN_RST;
		tap_slot = '0;
		win_count = '0;
		pred_total = '0;
		for (int a = 0; a < 3; a++) begin
			for (int t = 0; t < TAPS; t++)
				tap_ring[a][t] = '0;
			win_max[a] = 16'sh8000;
			win_min[a] = 16'sh7FFF;
			old_max[a] = '0;
			old_min[a] = '0;
			slide_now[a] = '0;
			slide_prev[a] = '0;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sample_extremes();
		test_span_ties();
		test_window_edges();
		test_gait_sequences();
		test_noise();

		drain_results();
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (mismatch_count == 0)
			$display("accel_pedometer_step_detector_core test passed");
		else
			$display("accel_pedometer_step_detector_core test failed");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/apsd_pkg.sv
hw/rtl/apsd_if.sv
hw/rtl/apsd_cfg_regs.sv
hw/rtl/apsd_mean.sv
hw/rtl/apsd_track.sv
hw/rtl/accel_pedometer_step_detector_core.sv
tb/tb_accel_pedometer_step_detector_core.sv
